// ===== rtl/core/alrc_pkg.sv =====
// ----------------------------------------------------------------------------
// alrc_pkg
// Types and constants shared by the left-to-right ASCII calculator.
// ----------------------------------------------------------------------------
package alrc_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [7:0] DIV_HUNDRED = 8'd100;
  localparam logic [7:0] DIV_TEN     = 8'd10;
  localparam logic [7:0] DIV0_VALUE  = 8'hFF;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } alrc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CONV_H,
    ST_CONV_T,
    ST_FINISH
  } alrc_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } alrc_in_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [1:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_ones;
    logic       div_zero_error;
  } alrc_out_t;

  typedef struct packed {
    logic       start;
    logic       op_div;
    logic [7:0] a;
    logic [7:0] b;
  } alrc_unit_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
    logic [7:0] rem;
  } alrc_unit_rsp_t;

endpackage

// ===== rtl/core/alrc_iter_unit.sv =====
// ----------------------------------------------------------------------------
// alrc_iter_unit
// Shared 8-bit multiply / divide unit, one bit per cycle, eight steps.
// Multiply is shift-add keeping the low byte; divide is restoring.
// ----------------------------------------------------------------------------
module alrc_iter_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  alrc_pkg::alrc_unit_req_t req,
  output alrc_pkg::alrc_unit_rsp_t rsp
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       div_r, div_nxt;
  logic [7:0] x_r, x_nxt;   // multiplicand / dividend, becomes quotient
  logic [7:0] y_r, y_nxt;   // multiplier / divisor
  logic [8:0] w_r, w_nxt;   // product / partial remainder

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;
  logic [7:0] addend;

  always_comb begin
    trial  = {w_r[7:0], x_r[7]};
    diff   = trial - {1'b0, y_r};
    fits   = (trial >= {1'b0, y_r});
    addend = y_r[0] ? x_r : 8'd0;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    w_nxt    = w_r;
    if (busy_r) begin
      if (div_r) begin
        w_nxt = fits ? diff : trial;
        x_nxt = {x_r[6:0], fits};
      end else begin
        w_nxt = {1'b0, w_r[7:0] + addend};
        x_nxt = {x_r[6:0], 1'b0};
        y_nxt = {1'b0, y_r[7:1]};
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      div_nxt  = req.op_div;
      x_nxt    = req.a;
      y_nxt    = req.b;
      w_nxt    = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    w_r   <= w_nxt;
  end

  always_comb begin
    rsp.done   = done_r;
    rsp.result = div_r ? x_r : w_r[7:0];
    rsp.rem    = w_r[7:0];
  end

endmodule

// ===== rtl/core/ascii_left_to_right_calculator.sv =====
// ----------------------------------------------------------------------------
// ascii_left_to_right_calculator
// Left-to-right ASCII expression evaluator with 8-bit wrapping arithmetic.
// ----------------------------------------------------------------------------
// Characters are taken one transaction at a time. A digit, an ignored code,
// or an operator whose pending operation is add, subtract, none or a divide
// by zero is taken without leaving the idle state. An operator with a pending
// multiply or divide runs the shared bit-serial unit before the next
// transaction is accepted. An end marker evaluates the pending operation,
// then uses the same unit twice to split the result into decimal digits
// (divide by 100, then by 10). The result sits in an output register, so a
// new expression can begin while it waits to be taken; only the next end
// marker stalls if the previous result is still there.
module ascii_left_to_right_calculator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alrc_pkg::alrc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alrc_pkg::alrc_out_t out_data
);

  alrc_pkg::alrc_state_t state_r, state_nxt;
  alrc_pkg::alrc_op_t    pending_r, pending_nxt;
  alrc_pkg::alrc_op_t    newop_r, newop_nxt;
  alrc_pkg::alrc_op_t    dec_op;
  logic [7:0]            acc_r, acc_nxt;
  logic [7:0]            operand_r, operand_nxt;
  logic                  err_r, err_nxt;
  logic                  fin_r, fin_nxt;
  logic [1:0]            hund_r, hund_nxt;
  logic [3:0]            tens_r, tens_nxt;
  logic [3:0]            ones_r, ones_nxt;
  logic                  out_valid_r, out_valid_nxt;
  alrc_pkg::alrc_out_t   out_r, out_nxt;

  alrc_pkg::alrc_unit_req_t req;
  alrc_pkg::alrc_unit_rsp_t rsp;

  logic       in_fire;
  logic       is_digit;
  logic       is_op;
  logic       fin;
  logic       apply;
  logic       pend_iter;
  logic       out_free;
  logic [7:0] imm_val;
  logic [7:0] operand_x10;

  alrc_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    unique case (in_data.char_code)
      alrc_pkg::CHAR_PLUS:  dec_op = alrc_pkg::OP_ADD;
      alrc_pkg::CHAR_MINUS: dec_op = alrc_pkg::OP_SUB;
      alrc_pkg::CHAR_STAR:  dec_op = alrc_pkg::OP_MUL;
      alrc_pkg::CHAR_SLASH: dec_op = alrc_pkg::OP_DIV;
      default:              dec_op = alrc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == alrc_pkg::ST_IDLE);
    in_fire     = in_valid && in_ready;
    fin         = in_data.end_of_expr;
    is_digit    = (in_data.char_code >= alrc_pkg::CHAR_0) &&
                  (in_data.char_code <= alrc_pkg::CHAR_9);
    is_op       = (dec_op != alrc_pkg::OP_NONE);
    apply       = in_fire && (fin || is_op);
    pend_iter   = (pending_r == alrc_pkg::OP_MUL) ||
                  ((pending_r == alrc_pkg::OP_DIV) && (operand_r != 8'd0));
    out_free    = !out_valid_r || out_ready;
    // x10 as x8 + x2, wrapping
    operand_x10 = {operand_r[4:0], 3'b000} + {operand_r[6:0], 1'b0};
    case (pending_r)
      alrc_pkg::OP_ADD: imm_val = acc_r + operand_r;
      alrc_pkg::OP_SUB: imm_val = acc_r - operand_r;
      alrc_pkg::OP_DIV: imm_val = alrc_pkg::DIV0_VALUE;  // only reached with zero divisor
      default:          imm_val = operand_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alrc_pkg::ST_IDLE: begin
        if (apply) begin
          if (pend_iter) state_nxt = alrc_pkg::ST_EVAL;
          else if (fin)  state_nxt = alrc_pkg::ST_CONV_H;
        end
      end
      alrc_pkg::ST_EVAL: begin
        if (rsp.done) state_nxt = fin_r ? alrc_pkg::ST_CONV_H : alrc_pkg::ST_IDLE;
      end
      alrc_pkg::ST_CONV_H: begin
        if (rsp.done) state_nxt = alrc_pkg::ST_CONV_T;
      end
      alrc_pkg::ST_CONV_T: begin
        if (rsp.done) state_nxt = alrc_pkg::ST_FINISH;
      end
      alrc_pkg::ST_FINISH: begin
        if (out_free) state_nxt = alrc_pkg::ST_IDLE;
      end
      default: state_nxt = alrc_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    pending_nxt   = pending_r;
    newop_nxt     = newop_r;
    acc_nxt       = acc_r;
    operand_nxt   = operand_r;
    err_nxt       = err_r;
    fin_nxt       = fin_r;
    hund_nxt      = hund_r;
    tens_nxt      = tens_r;
    ones_nxt      = ones_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    req.start     = 1'b0;
    req.op_div    = 1'b1;
    req.a         = acc_r;
    req.b         = operand_r;
    unique case (state_r)
      alrc_pkg::ST_IDLE: begin
        if (in_fire && !fin && is_digit) begin
          operand_nxt = operand_x10 + {4'd0, in_data.char_code[3:0]};
        end
        if (apply) begin
          fin_nxt   = fin;
          newop_nxt = fin ? alrc_pkg::OP_NONE : dec_op;
          if (pend_iter) begin
            req.start  = 1'b1;
            req.op_div = (pending_r == alrc_pkg::OP_DIV);
          end else begin
            acc_nxt     = imm_val;
            operand_nxt = 8'd0;
            pending_nxt = fin ? alrc_pkg::OP_NONE : dec_op;
            if (pending_r == alrc_pkg::OP_DIV) err_nxt = 1'b1;
            if (fin) begin
              req.start = 1'b1;
              req.a     = imm_val;
              req.b     = alrc_pkg::DIV_HUNDRED;
            end
          end
        end
      end
      alrc_pkg::ST_EVAL: begin
        if (rsp.done) begin
          acc_nxt     = rsp.result;
          operand_nxt = 8'd0;
          pending_nxt = newop_r;
          if (fin_r) begin
            req.start = 1'b1;
            req.a     = rsp.result;
            req.b     = alrc_pkg::DIV_HUNDRED;
          end
        end
      end
      alrc_pkg::ST_CONV_H: begin
        if (rsp.done) begin
          hund_nxt  = rsp.result[1:0];
          req.start = 1'b1;
          req.a     = rsp.rem;
          req.b     = alrc_pkg::DIV_TEN;
        end
      end
      alrc_pkg::ST_CONV_T: begin
        if (rsp.done) begin
          tens_nxt = rsp.result[3:0];
          ones_nxt = rsp.rem[3:0];
        end
      end
      alrc_pkg::ST_FINISH: begin
        if (out_free) begin
          out_nxt.result_value   = acc_r;
          out_nxt.digit_hundreds = hund_r;
          out_nxt.digit_tens     = tens_r;
          out_nxt.digit_ones     = ones_r;
          out_nxt.div_zero_error = err_r;
          out_valid_nxt          = 1'b1;
          acc_nxt                = 8'd0;
          operand_nxt            = 8'd0;
          pending_nxt            = alrc_pkg::OP_NONE;
          err_nxt                = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alrc_pkg::ST_IDLE;
      pending_r   <= alrc_pkg::OP_NONE;
      acc_r       <= 8'd0;
      operand_r   <= 8'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      acc_r       <= acc_nxt;
      operand_r   <= operand_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    newop_r <= newop_nxt;
    fin_r   <= fin_nxt;
    hund_r  <= hund_nxt;
    tens_r  <= tens_nxt;
    ones_r  <= ones_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_ascii_left_to_right_calculator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_left_to_right_calculator
// Self-checking bench for the left-to-right ASCII calculator.
// ----------------------------------------------------------------------------
// Feeds character transactions: a few fixed expressions, then random
// expressions mixed with ignored codes and broken sequences. Each accepted
// transaction goes through a local evaluator that builds the expected result
// on every end marker. Each result taken from the block is compared field by
// field with the oldest expected one. Both channels idle at random, and once
// the result side holds off long enough to back up the character side.
// ----------------------------------------------------------------------------
module tb_ascii_left_to_right_calculator;

  localparam int CHAR_ITEMS  = 1850;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 1000000;

  // Evaluates the character stream and keeps the results still owed.
  class calc_scoreboard;
    logic [7:0]          acc;
    logic [7:0]          operand;
    alrc_pkg::alrc_op_t  op;
    logic                div_err;
    alrc_pkg::alrc_out_t results_due[$];
    int                  mismatches;

    function new();
      mismatches = 0;
      clear_expr();
    endfunction

    function void clear_expr();
      acc     = '0;
      operand = '0;
      op      = alrc_pkg::OP_NONE;
      div_err = 1'b0;
    endfunction

    // Fold the operand into the accumulator with the waiting operator.
    function void settle_op();
      case (op)
        alrc_pkg::OP_ADD: acc = acc + operand;
        alrc_pkg::OP_SUB: acc = acc - operand;
        alrc_pkg::OP_MUL: acc = acc * operand;
        alrc_pkg::OP_DIV: begin
          if (operand == 8'd0) begin
            acc     = alrc_pkg::DIV0_VALUE;
            div_err = 1'b1;
          end else begin
            acc = acc / operand;
          end
        end
        default: acc = operand;
      endcase
      operand = '0;
      op      = alrc_pkg::OP_NONE;
    endfunction

    function void note_input(alrc_pkg::alrc_in_t t);
      alrc_pkg::alrc_out_t r;
      if (t.end_of_expr) begin
        settle_op();
        r.result_value   = acc;
        r.digit_hundreds = 2'(acc / 8'd100);
        r.digit_tens     = 4'((acc / 8'd10) % 8'd10);
        r.digit_ones     = 4'(acc % 8'd10);
        r.div_zero_error = div_err;
        results_due.push_back(r);
        clear_expr();
      end else if (t.char_code >= alrc_pkg::CHAR_0 && t.char_code <= alrc_pkg::CHAR_9) begin
        operand = 8'(operand * 8'd10 + (t.char_code - alrc_pkg::CHAR_0));
      end else begin
        case (t.char_code)
          alrc_pkg::CHAR_PLUS:  begin settle_op(); op = alrc_pkg::OP_ADD; end
          alrc_pkg::CHAR_MINUS: begin settle_op(); op = alrc_pkg::OP_SUB; end
          alrc_pkg::CHAR_STAR:  begin settle_op(); op = alrc_pkg::OP_MUL; end
          alrc_pkg::CHAR_SLASH: begin settle_op(); op = alrc_pkg::OP_DIV; end
          default: ;
        endcase
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(alrc_pkg::alrc_out_t got);
      alrc_pkg::alrc_out_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", got.result_value));
      end else begin
        want = results_due.pop_front();
        if (got.result_value !== want.result_value)
          report_mismatch($sformatf("result_value got %0d want %0d",
                                    got.result_value, want.result_value));
        if (got.digit_hundreds !== want.digit_hundreds)
          report_mismatch($sformatf("digit_hundreds got %0d want %0d",
                                    got.digit_hundreds, want.digit_hundreds));
        if (got.digit_tens !== want.digit_tens)
          report_mismatch($sformatf("digit_tens got %0d want %0d",
                                    got.digit_tens, want.digit_tens));
        if (got.digit_ones !== want.digit_ones)
          report_mismatch($sformatf("digit_ones got %0d want %0d",
                                    got.digit_ones, want.digit_ones));
        if (got.div_zero_error !== want.div_zero_error)
          report_mismatch($sformatf("div_zero_error got %0d want %0d",
                                    got.div_zero_error, want.div_zero_error));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  alrc_pkg::alrc_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  alrc_pkg::alrc_out_t out_data;

  calc_scoreboard sb;
  int  cycles;
  int  active_sent;
  bit  no_idle;
  bit  hold_req;

  ascii_left_to_right_calculator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: sample accepted transactions at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side ready pattern, including the long hold-off.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  function automatic alrc_pkg::alrc_in_t mk(logic [7:0] c, logic e);
    alrc_pkg::alrc_in_t t;
    t.char_code   = c;
    t.end_of_expr = e;
    return t;
  endfunction

  function automatic bit is_active(alrc_pkg::alrc_in_t t);
    return t.end_of_expr ||
           (t.char_code >= alrc_pkg::CHAR_0 && t.char_code <= alrc_pkg::CHAR_9) ||
           t.char_code == alrc_pkg::CHAR_PLUS || t.char_code == alrc_pkg::CHAR_MINUS ||
           t.char_code == alrc_pkg::CHAR_STAR || t.char_code == alrc_pkg::CHAR_SLASH;
  endfunction

  task automatic send_item(alrc_pkg::alrc_in_t t);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    if (is_active(t)) active_sent++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_end();
    send_item(mk(8'($urandom_range(0, 255)), 1'b1));
  endtask

  task automatic send_expr(string s);
    for (int i = 0; i < s.len(); i++) send_item(mk(s[i], 1'b0));
    send_end();
  endtask

  task automatic send_op();
    case ($urandom_range(0, 3))
      0: send_item(mk(alrc_pkg::CHAR_PLUS, 1'b0));
      1: send_item(mk(alrc_pkg::CHAR_MINUS, 1'b0));
      2: send_item(mk(alrc_pkg::CHAR_STAR, 1'b0));
      default: send_item(mk(alrc_pkg::CHAR_SLASH, 1'b0));
    endcase
  endtask

  task automatic send_digit();
    send_item(mk(alrc_pkg::CHAR_0 + 8'($urandom_range(0, 9)), 1'b0));
  endtask

  // Operand of 0..3 digits; a lone zero is frequent to hit divide by zero.
  task automatic send_number();
    int nd;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) nd = 0;
    else if (r < 16) begin
      send_item(mk(alrc_pkg::CHAR_0, 1'b0));
      return;
    end
    else if (r < 60) nd = 1;
    else if (r < 88) nd = 2;
    else nd = 3;
    repeat (nd) send_digit();
  endtask

  task automatic send_random_expr();
    int terms;
    terms = $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) send_op();
    for (int k = 0; k < terms; k++) begin
      if (k > 0) send_op();
      if ($urandom_range(0, 19) == 0) send_item(mk(8'($urandom_range(0, 255)), 1'b0));
      send_number();
    end
    if ($urandom_range(0, 9) == 0) send_op();
    send_end();
  endtask

  // Any code at all, end marker now and then.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item(mk(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0)));
  endtask

  // Active codes in no particular order.
  task automatic send_broken();
    repeat ($urandom_range(2, 8)) begin
      case ($urandom_range(0, 5))
        0, 1, 2: send_digit();
        3, 4: send_op();
        default: send_end();
      endcase
    end
  endtask

  initial begin
    bit pressure_done;
    int r;
    sb            = new();
    cycles        = 0;
    active_sent   = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    pressure_done = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty expression.
    send_item(mk(8'h00, 1'b1));
    // Wrapping entry, multiply, subtract, then divide by zero at the end.
    send_expr("999*2-8/0");
    // Divide by zero in the middle; error stays set to the end.
    send_expr("5/0+3");
    // Ignored codes inside an expression; end marker carries an operator code.
    send_item(mk("1", 1'b0));
    send_item(mk(8'hFF, 1'b0));
    send_item(mk(8'h00, 1'b0));
    send_item(mk("2", 1'b0));
    send_item(mk(alrc_pkg::CHAR_PLUS, 1'b1));
    // Floor division.
    send_expr("6/4");

    while (active_sent < CHAR_ITEMS) begin
      no_idle = (active_sent >= 500 && active_sent < 800);
      if (!pressure_done && active_sent >= 1200) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 85) send_random_expr();
      else if (r < 93) send_noise();
      else send_broken();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
